// ===== rtl/dtst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtst_pkg
// Request codes, controller states and the command and status bundles that
// join the controller to the datapath of the dirty tile and sector tracker.
// ----------------------------------------------------------------------------
package dtst_pkg;

    // Request codes carried by req_type. Codes 6 and 7 are unused.
    typedef enum logic [2:0] {
        REQ_MARK_RECT = 3'd0,
        REQ_MARK_ALL  = 3'd1,
        REQ_CAPTURE   = 3'd2,
        REQ_ACK       = 3'd3,
        REQ_QUERY     = 3'd4,
        REQ_CLEAR     = 3'd5
    } t_req;

    typedef enum logic [4:0] {
        ST_RESET = 5'b00001,
        ST_INIT  = 5'b00010,
        ST_IDLE  = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_clear;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_sts;

    // Width of the signed coordinate compares.
    localparam int CMP_W = 18;

    localparam int COORD_W  = 16;
    localparam int TILE_W   = 10;
    localparam int SECTOR_W = 10;
    localparam int CAPT_W   = 9;
    localparam int PEND_W   = 7;

endpackage

// ===== rtl/dirty_tile_sector_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_tile_sector_tracker
// Tracks marked tiles of a tiled canvas and the sectors pending a save.
// ----------------------------------------------------------------------------
// Each request (mark rectangle, mark all, capture, acknowledge, query, clear)
// yields one result transaction. Every request with a defined code sweeps the
// sector memory one sector word per cycle through a read-modify-write
// pipeline, and its result is loaded into the output register once the sweep
// has drained and that register is free; the memory holds SECTOR_COUNT words,
// where SECTOR_COUNT is ceil(TILES_ACROSS * TILES_DOWN / TILES_PER_SECTOR).
// Unused codes skip the sweep. The next request is accepted in the cycle after
// the result is loaded, even while that result still waits on the output.
// After reset a clearing pass over every sector runs with o_in_stall high.
// ----------------------------------------------------------------------------
module dirty_tile_sector_tracker #(
    parameter int TILE_SIZE        = 16,
    parameter int TILES_ACROSS     = 16,
    parameter int TILES_DOWN       = 16,
    parameter int TILES_PER_SECTOR = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic        [2:0]                   i_req_type,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_left_x,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_top_y,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_right_x,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_bottom_y,
    input  logic [dtst_pkg::TILE_W-1:0]         i_tile_number,
    input  logic [dtst_pkg::SECTOR_W-1:0]       i_sector_number,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dtst_pkg::CAPT_W-1:0]         o_captured_count,
    output logic                                o_tile_marked,
    output logic                                o_sector_is_pending,
    output logic [dtst_pkg::PEND_W-1:0]         o_pending_total
);

    dtst_pkg::t_dp_cmd cmd;
    dtst_pkg::t_dp_sts sts;

    dtst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dtst_dp #(
        .TILE_SIZE        (TILE_SIZE),
        .TILES_ACROSS     (TILES_ACROSS),
        .TILES_DOWN       (TILES_DOWN),
        .TILES_PER_SECTOR (TILES_PER_SECTOR)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_req_type          (i_req_type),
        .i_left_x            (i_left_x),
        .i_top_y             (i_top_y),
        .i_right_x           (i_right_x),
        .i_bottom_y          (i_bottom_y),
        .i_tile_number       (i_tile_number),
        .i_sector_number     (i_sector_number),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_captured_count    (o_captured_count),
        .o_tile_marked       (o_tile_marked),
        .o_sector_is_pending (o_sector_is_pending),
        .o_pending_total     (o_pending_total)
    );

endmodule

// ===== rtl/dtst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtst_ctrl
// Request sequencer: runs the clearing pass after reset, accepts one request
// at a time, waits for any sector sweep and hands the result to the output.
// ----------------------------------------------------------------------------
module dtst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_req_type,
    input  dtst_pkg::t_dp_sts i_sts,
    output dtst_pkg::t_dp_cmd o_cmd,
    output logic              o_in_stall
);

    dtst_pkg::t_state r_state;
    dtst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtst_pkg::ST_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            dtst_pkg::ST_RESET: begin
                o_cmd.start_clear = 1'b1;
                n_state           = dtst_pkg::ST_INIT;
            end
            dtst_pkg::ST_INIT: begin
                if (!i_sts.busy) begin
                    n_state = dtst_pkg::ST_IDLE;
                end
            end
            dtst_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // Unused request codes need no sweep.
                    if (i_req_type <= 3'(dtst_pkg::REQ_CLEAR)) begin
                        n_state = dtst_pkg::ST_RUN;
                    end else begin
                        n_state = dtst_pkg::ST_DONE;
                    end
                end
            end
            dtst_pkg::ST_RUN: begin
                if (!i_sts.busy) begin
                    n_state = dtst_pkg::ST_DONE;
                end
            end
            dtst_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dtst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dtst_pkg::ST_RESET;
            end
        endcase
    end

    assign o_in_stall = (r_state != dtst_pkg::ST_IDLE);

endmodule

// ===== rtl/dtst_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtst_dp
// Datapath: one memory word per sector holds its pending flag and tile marks.
// Defined requests and the clearing pass sweep the sectors in a two-stage
// read-modify-write pipeline; per-tile lanes track each tile's pixel origin.
// ----------------------------------------------------------------------------
module dtst_dp #(
    parameter int TILE_SIZE        = 16,
    parameter int TILES_ACROSS     = 16,
    parameter int TILES_DOWN       = 16,
    parameter int TILES_PER_SECTOR = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dtst_pkg::t_dp_cmd                   i_cmd,
    output dtst_pkg::t_dp_sts                   o_sts,
    input  logic        [2:0]                   i_req_type,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_left_x,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_top_y,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_right_x,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_bottom_y,
    input  logic [dtst_pkg::TILE_W-1:0]         i_tile_number,
    input  logic [dtst_pkg::SECTOR_W-1:0]       i_sector_number,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [dtst_pkg::CAPT_W-1:0]         o_captured_count,
    output logic                                o_tile_marked,
    output logic                                o_sector_is_pending,
    output logic [dtst_pkg::PEND_W-1:0]         o_pending_total
);

    localparam int TPS          = TILES_PER_SECTOR;
    localparam int TILE_COUNT   = TILES_ACROSS * TILES_DOWN;
    localparam int SECTOR_COUNT = (TILE_COUNT + TPS - 1) / TPS;
    localparam int CANVAS_W     = TILE_SIZE * TILES_ACROSS;
    localparam int CANVAS_H     = TILE_SIZE * TILES_DOWN;
    localparam int AW           = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int SW           = $clog2(SECTOR_COUNT + 1);
    localparam int PCW          = $clog2(SECTOR_COUNT + 1);
    localparam int PW           = $clog2(TPS + 1);
    localparam int LQ           = TPS / TILES_ACROSS;
    localparam int LR           = TPS % TILES_ACROSS;
    localparam int XSTEP        = LR * TILE_SIZE;
    localparam int YSTEP        = LQ * TILE_SIZE;
    localparam int PXW          = $clog2(CANVAS_W);
    localparam int PYW          = $clog2(CANVAS_H + (LQ + 2) * TILE_SIZE + 1);
    localparam int BTW          = $clog2(SECTOR_COUNT * TPS + 1);
    localparam int CTW          = (BTW > dtst_pkg::TILE_W) ? BTW : dtst_pkg::TILE_W;
    localparam int SNW          = (SW > dtst_pkg::SECTOR_W) ? SW : dtst_pkg::SECTOR_W;
    localparam int CW           = dtst_pkg::CMP_W;

    function automatic logic [PW-1:0] f_pop(input logic [TPS-1:0] v);
        logic [PW-1:0] n;
        n = '0;
        for (int k = 0; k < TPS; k++) begin
            n = n + PW'(v[k]);
        end
        return n;
    endfunction

    // Sector memory: bit TPS is the pending flag, the rest are tile marks.
    logic [TPS:0] r_mem [SECTOR_COUNT];
    logic [TPS:0] r_rd_data;

    // Request registers.
    logic [2:0]              r_op;
    logic signed [CW-1:0]    r_xlo;
    logic signed [CW-1:0]    r_x1;
    logic signed [CW-1:0]    r_ylo;
    logic signed [CW-1:0]    r_y1;
    logic [dtst_pkg::TILE_W-1:0]   r_tile;
    logic [dtst_pkg::SECTOR_W-1:0] r_sector;

    // Sweep issue stage.
    logic            r_run;
    logic [SW-1:0]   r_s;
    logic [BTW-1:0]  r_base;
    logic [PXW-1:0]  r_lx [TPS];
    logic [PYW-1:0]  r_ly [TPS];

    // Sweep write stage.
    logic            r_s1_v;
    logic [AW-1:0]   r_s1_addr;
    logic [TPS-1:0]  r_s1_rect;
    logic [TPS-1:0]  r_s1_valid;
    logic [TPS-1:0]  r_s1_thit;
    logic            r_s1_shit;

    // Accumulators and result.
    logic [PCW-1:0]               r_pending;
    logic [dtst_pkg::CAPT_W-1:0]  r_cnt;
    logic                         r_qt;
    logic                         r_qs;
    logic                         r_out_valid;
    logic [dtst_pkg::CAPT_W-1:0]  r_o_cnt;
    logic                         r_o_qt;
    logic                         r_o_qs;
    logic [dtst_pkg::PEND_W-1:0]  r_o_pend;

    logic           start;
    logic [AW-1:0]  rd_addr;
    logic [TPS-1:0] rect;
    logic [TPS-1:0] lvalid;
    logic [TPS-1:0] thit;
    logic           shit;
    logic [PXW-1:0] n_lx [TPS];
    logic [PYW-1:0] n_ly [TPS];

    assign start   = i_cmd.accept | i_cmd.start_clear;
    assign rd_addr = r_s[AW-1:0];
    assign shit    = (SNW'(r_s) == SNW'(r_sector));

    // Per-tile lanes: hit tests for the sector being issued, and the step to
    // the same lane of the next sector (one wrap at most, as the column
    // advance stays below one canvas width).
    for (genvar j = 0; j < TPS; j++) begin : g_lane
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic [PXW:0]         xsum;
        logic                 wrap;

        assign px = $signed(CW'(r_lx[j]));
        assign py = $signed(CW'(r_ly[j]));
        assign rect[j]   = (px >= r_xlo) && (px <= r_x1) && (py >= r_ylo) && (py <= r_y1);
        assign lvalid[j] = (r_ly[j] < PYW'(CANVAS_H));
        assign thit[j]   = ((CTW'(r_base) + CTW'(j)) == CTW'(r_tile));

        assign xsum    = {1'b0, r_lx[j]} + (PXW + 1)'(XSTEP);
        assign wrap    = (xsum >= (PXW + 1)'(CANVAS_W));
        assign n_lx[j] = wrap ? PXW'(xsum - (PXW + 1)'(CANVAS_W)) : PXW'(xsum);
        assign n_ly[j] = r_ly[j] + PYW'(YSTEP) + (wrap ? PYW'(TILE_SIZE) : PYW'(0));
    end

    // Issue stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_s1_v <= 1'b0;
        end else begin
            if (start) begin
                r_run <= i_cmd.start_clear | (i_req_type <= 3'(dtst_pkg::REQ_CLEAR));
            end else if (r_run && (r_s == SW'(SECTOR_COUNT - 1))) begin
                r_run <= 1'b0;
            end
            r_s1_v <= r_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_s    <= '0;
            r_base <= '0;
            for (int j = 0; j < TPS; j++) begin
                r_lx[j] <= PXW'((j % TILES_ACROSS) * TILE_SIZE);
                r_ly[j] <= PYW'((j / TILES_ACROSS) * TILE_SIZE);
            end
        end else if (r_run) begin
            r_s    <= r_s + SW'(1);
            r_base <= r_base + BTW'(TPS);
            for (int j = 0; j < TPS; j++) begin
                r_lx[j] <= n_lx[j];
                r_ly[j] <= n_ly[j];
            end
        end
        if (i_cmd.accept) begin
            r_op     <= i_req_type;
            r_xlo    <= CW'(i_left_x) - $signed(CW'(TILE_SIZE - 1));
            r_x1     <= CW'(i_right_x);
            r_ylo    <= CW'(i_top_y) - $signed(CW'(TILE_SIZE - 1));
            r_y1     <= CW'(i_bottom_y);
            r_tile   <= i_tile_number;
            r_sector <= i_sector_number;
        end else if (i_cmd.start_clear) begin
            r_op <= 3'(dtst_pkg::REQ_CLEAR);
        end
        r_s1_addr  <= rd_addr;
        r_s1_rect  <= rect;
        r_s1_valid <= lvalid;
        r_s1_thit  <= thit;
        r_s1_shit  <= shit;
    end

    // Memory: registered read in the issue stage, write in the write stage.
    logic [TPS-1:0] old_tiles;
    logic           old_flag;
    logic [TPS-1:0] n_tiles;
    logic           n_flag;
    logic           pend_inc;
    logic           pend_dec;

    assign old_tiles = r_rd_data[TPS-1:0];
    assign old_flag  = r_rd_data[TPS];

    always_ff @(posedge i_clk) begin
        if (r_run) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (r_s1_v) begin
            r_mem[r_s1_addr] <= {n_flag, n_tiles};
        end
    end

    always_comb begin
        n_tiles  = old_tiles;
        n_flag   = old_flag;
        pend_inc = 1'b0;
        pend_dec = 1'b0;
        case (r_op)
            dtst_pkg::REQ_MARK_RECT: begin
                n_tiles = old_tiles | (r_s1_rect & r_s1_valid);
            end
            dtst_pkg::REQ_MARK_ALL: begin
                n_tiles = old_tiles | r_s1_valid;
            end
            dtst_pkg::REQ_CAPTURE: begin
                n_tiles  = '0;
                n_flag   = old_flag | (|old_tiles);
                pend_inc = (|old_tiles) & ~old_flag;
            end
            dtst_pkg::REQ_ACK: begin
                if (r_s1_shit) begin
                    n_flag   = 1'b0;
                    pend_dec = old_flag;
                end
            end
            dtst_pkg::REQ_CLEAR: begin
                n_tiles = '0;
                n_flag  = 1'b0;
            end
            default: begin
                n_tiles = old_tiles;
            end
        endcase
    end

    // Accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (i_cmd.start_clear
                     || (i_cmd.accept && (i_req_type == 3'(dtst_pkg::REQ_CLEAR)))) begin
            r_pending <= '0;
        end else if (r_s1_v) begin
            if (pend_inc) begin
                r_pending <= r_pending + PCW'(1);
            end else if (pend_dec) begin
                r_pending <= r_pending - PCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cnt <= '0;
            r_qt  <= 1'b0;
            r_qs  <= 1'b0;
        end else if (r_s1_v) begin
            if (r_op == 3'(dtst_pkg::REQ_CAPTURE)) begin
                r_cnt <= r_cnt + dtst_pkg::CAPT_W'(f_pop(old_tiles));
            end
            if (r_op == 3'(dtst_pkg::REQ_QUERY)) begin
                r_qt <= r_qt | (|(old_tiles & r_s1_thit));
                r_qs <= r_qs | (r_s1_shit & old_flag);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_cnt  <= r_cnt;
            r_o_qt   <= r_qt;
            r_o_qs   <= r_qs;
            r_o_pend <= dtst_pkg::PEND_W'(r_pending);
        end
    end

    assign o_sts.busy     = r_run | r_s1_v;
    assign o_sts.out_free = ~r_out_valid | ~i_out_stall;

    assign o_out_valid         = r_out_valid;
    assign o_captured_count    = r_o_cnt;
    assign o_tile_marked       = r_o_qt;
    assign o_sector_is_pending = r_o_qs;
    assign o_pending_total     = r_o_pend;

endmodule

// ===== rtl/dtst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtst_checker
// Port-level checks of the dirty tile and sector tracker, bound to its top.
// ----------------------------------------------------------------------------
module dtst_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [dtst_pkg::CAPT_W-1:0]         o_captured_count,
    input logic                                o_tile_marked,
    input logic                                o_sector_is_pending,
    input logic [dtst_pkg::PEND_W-1:0]         o_pending_total
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_captured_count)
            && $stable(o_tile_marked) && $stable(o_sector_is_pending)
            && $stable(o_pending_total))
        else $error("stalled result changed");

    // The clearing pass keeps the input closed right after reset.
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open right after reset");

    // Only one request is in flight at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request accepted back to back");

    // A capture result never carries query bits.
    a_capture_no_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_tile_marked || o_sector_is_pending)
            |-> o_captured_count == '0)
        else $error("query result reports captured tiles");

endmodule

bind dirty_tile_sector_tracker dtst_checker u_dtst_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_captured_count    (o_captured_count),
    .o_tile_marked       (o_tile_marked),
    .o_sector_is_pending (o_sector_is_pending),
    .o_pending_total     (o_pending_total)
);

// ===== sim/dtst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtst_scoreboard
// Watches both channels of the dirty tile and sector tracker. It keeps its own
// tile and sector stores, works out the result of each accepted request, and
// compares each accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module dtst_scoreboard #(
    parameter int TILE_SIZE        = 16,
    parameter int TILES_ACROSS     = 16,
    parameter int TILES_DOWN       = 16,
    parameter int TILES_PER_SECTOR = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic        [2:0]                   i_req_type,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_left_x,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_top_y,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_right_x,
    input  logic signed [dtst_pkg::COORD_W-1:0] i_bottom_y,
    input  logic [dtst_pkg::TILE_W-1:0]         i_tile_number,
    input  logic [dtst_pkg::SECTOR_W-1:0]       i_sector_number,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [dtst_pkg::CAPT_W-1:0]         i_captured_count,
    input  logic                                i_tile_marked,
    input  logic                                i_sector_is_pending,
    input  logic [dtst_pkg::PEND_W-1:0]         i_pending_total,
    output int                                  o_fail_count,
    output int                                  o_results_owed
);

    localparam int CANVAS_W     = TILE_SIZE * TILES_ACROSS;
    localparam int CANVAS_H     = TILE_SIZE * TILES_DOWN;
    localparam int TILE_COUNT   = TILES_ACROSS * TILES_DOWN;
    localparam int SECTOR_COUNT = (TILE_COUNT + TILES_PER_SECTOR - 1) / TILES_PER_SECTOR;

    typedef struct packed {
        logic [dtst_pkg::CAPT_W-1:0] captured;
        logic                        tile_marked;
        logic                        sector_flagged;
        logic [dtst_pkg::PEND_W-1:0] pending_total;
    } tracker_result_t;

    bit              tile_marks   [TILE_COUNT];
    bit              sector_flags [SECTOR_COUNT];
    tracker_result_t owed_results [$];
    tracker_result_t oldest;

    initial begin
        o_fail_count   = 0;
        o_results_owed = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic int clamp_coord(input int v, input int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // Applies one request to the local stores and returns the result it yields.
    function automatic tracker_result_t apply_request(
        input logic        [2:0]  kind,
        input logic signed [15:0] lx,
        input logic signed [15:0] ty,
        input logic signed [15:0] rx,
        input logic signed [15:0] by,
        input logic        [9:0]  tile,
        input logic        [9:0]  sector
    );
        tracker_result_t res;
        int x0, y0, x1, y1;
        int row, col, t, s;
        int moved, pend;
        res   = '0;
        moved = 0;
        pend  = 0;
        case (kind)
            dtst_pkg::REQ_MARK_RECT: begin
                x0 = lx;
                y0 = ty;
                x1 = rx;
                y1 = by;
                // A rectangle wholly off the canvas is dropped before any clamp.
                if (!(x1 < 0 || y1 < 0 || x0 >= CANVAS_W || y0 >= CANVAS_H)) begin
                    x0 = clamp_coord(x0, CANVAS_W - 1);
                    y0 = clamp_coord(y0, CANVAS_H - 1);
                    x1 = clamp_coord(x1, CANVAS_W - 1);
                    y1 = clamp_coord(y1, CANVAS_H - 1);
                    for (row = y0 / TILE_SIZE; row <= y1 / TILE_SIZE; row++) begin
                        for (col = x0 / TILE_SIZE; col <= x1 / TILE_SIZE; col++) begin
                            tile_marks[row * TILES_ACROSS + col] = 1'b1;
                        end
                    end
                end
            end
            dtst_pkg::REQ_MARK_ALL: begin
                for (t = 0; t < TILE_COUNT; t++) tile_marks[t] = 1'b1;
            end
            dtst_pkg::REQ_CAPTURE: begin
                for (t = 0; t < TILE_COUNT; t++) begin
                    if (tile_marks[t]) begin
                        sector_flags[t / TILES_PER_SECTOR] = 1'b1;
                        tile_marks[t] = 1'b0;
                        moved++;
                    end
                end
                res.captured = moved[dtst_pkg::CAPT_W-1:0];
            end
            dtst_pkg::REQ_ACK: begin
                if (sector < SECTOR_COUNT) sector_flags[sector] = 1'b0;
            end
            dtst_pkg::REQ_QUERY: begin
                res.tile_marked    = (tile < TILE_COUNT) && tile_marks[tile];
                res.sector_flagged = (sector < SECTOR_COUNT) && sector_flags[sector];
            end
            dtst_pkg::REQ_CLEAR: begin
                for (t = 0; t < TILE_COUNT; t++) tile_marks[t] = 1'b0;
                for (s = 0; s < SECTOR_COUNT; s++) sector_flags[s] = 1'b0;
            end
            default: ;
        endcase
        for (s = 0; s < SECTOR_COUNT; s++) pend += sector_flags[s];
        res.pending_total = pend[dtst_pkg::PEND_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (tile_marks[t]) tile_marks[t] = 1'b0;
            foreach (sector_flags[s]) sector_flags[s] = 1'b0;
            owed_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                owed_results.push_back(apply_request(i_req_type, i_left_x, i_top_y,
                    i_right_x, i_bottom_y, i_tile_number, i_sector_number));
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result transaction with no request outstanding");
                end else begin
                    oldest = owed_results.pop_front();
                    if (i_captured_count !== oldest.captured)
                        report_mismatch($sformatf("captured_count got %0d expected %0d",
                            i_captured_count, oldest.captured));
                    if (i_tile_marked !== oldest.tile_marked)
                        report_mismatch($sformatf("tile_marked got %0b expected %0b",
                            i_tile_marked, oldest.tile_marked));
                    if (i_sector_is_pending !== oldest.sector_flagged)
                        report_mismatch($sformatf("sector_is_pending got %0b expected %0b",
                            i_sector_is_pending, oldest.sector_flagged));
                    if (i_pending_total !== oldest.pending_total)
                        report_mismatch($sformatf("pending_total got %0d expected %0d",
                            i_pending_total, oldest.pending_total));
                end
            end
        end
        o_results_owed <= owed_results.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Request stimulus for the dirty tile and sector tracker: a directed opening
// over the canvas borders and every request code, then weighted random
// requests with random gaps on the request side and random back-pressure on
// the result side. The scoreboard beside the block reports the failures.
// ----------------------------------------------------------------------------
module tb;

    localparam int TILE_SIZE        = 16;
    localparam int TILES_ACROSS     = 16;
    localparam int TILES_DOWN       = 16;
    localparam int TILES_PER_SECTOR = 4;

    localparam int CANVAS_W     = TILE_SIZE * TILES_ACROSS;
    localparam int TILE_COUNT   = TILES_ACROSS * TILES_DOWN;
    localparam int SECTOR_COUNT = (TILE_COUNT + TILES_PER_SECTOR - 1) / TILES_PER_SECTOR;

    localparam int RANDOM_ITEMS = 1125;
    localparam int DRAIN_ITEM   = 600;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Request codes the package leaves unnamed; the block must ignore them.
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    typedef struct {
        logic        [2:0]  kind;
        logic signed [15:0] lx;
        logic signed [15:0] ty;
        logic signed [15:0] rx;
        logic signed [15:0] by;
        logic        [9:0]  tile;
        logic        [9:0]  sector;
    } tracker_req_t;

    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_in_valid      = 1'b0;
    logic                                o_in_stall;
    logic        [2:0]                   i_req_type      = '0;
    logic signed [dtst_pkg::COORD_W-1:0] i_left_x        = '0;
    logic signed [dtst_pkg::COORD_W-1:0] i_top_y         = '0;
    logic signed [dtst_pkg::COORD_W-1:0] i_right_x       = '0;
    logic signed [dtst_pkg::COORD_W-1:0] i_bottom_y      = '0;
    logic [dtst_pkg::TILE_W-1:0]         i_tile_number   = '0;
    logic [dtst_pkg::SECTOR_W-1:0]       i_sector_number = '0;
    logic                                o_out_valid;
    logic                                i_out_stall     = 1'b0;
    logic [dtst_pkg::CAPT_W-1:0]         o_captured_count;
    logic                                o_tile_marked;
    logic                                o_sector_is_pending;
    logic [dtst_pkg::PEND_W-1:0]         o_pending_total;

    int          fail_count;
    int          results_owed;
    int unsigned cycle_count = 0;
    int          stall_hold  = 0;
    int          stall_roll;
    int          calm_items  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    dirty_tile_sector_tracker #(
        .TILE_SIZE       (TILE_SIZE),
        .TILES_ACROSS    (TILES_ACROSS),
        .TILES_DOWN      (TILES_DOWN),
        .TILES_PER_SECTOR(TILES_PER_SECTOR)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_left_x           (i_left_x),
        .i_top_y            (i_top_y),
        .i_right_x          (i_right_x),
        .i_bottom_y         (i_bottom_y),
        .i_tile_number      (i_tile_number),
        .i_sector_number    (i_sector_number),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_captured_count   (o_captured_count),
        .o_tile_marked      (o_tile_marked),
        .o_sector_is_pending(o_sector_is_pending),
        .o_pending_total    (o_pending_total)
    );

    dtst_scoreboard #(
        .TILE_SIZE       (TILE_SIZE),
        .TILES_ACROSS    (TILES_ACROSS),
        .TILES_DOWN      (TILES_DOWN),
        .TILES_PER_SECTOR(TILES_PER_SECTOR)
    ) u_scoreboard (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_left_x           (i_left_x),
        .i_top_y            (i_top_y),
        .i_right_x          (i_right_x),
        .i_bottom_y         (i_bottom_y),
        .i_tile_number      (i_tile_number),
        .i_sector_number    (i_sector_number),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_captured_count   (o_captured_count),
        .i_tile_marked      (o_tile_marked),
        .i_sector_is_pending(o_sector_is_pending),
        .i_pending_total    (o_pending_total),
        .o_fail_count       (fail_count),
        .o_results_owed     (results_owed)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result-side back-pressure: free runs of varying length, mostly short
    // stalls, and now and then a long one.
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 8) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(100, 400);
            end else if (stall_roll < 50) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(0, 20);
            end else if (stall_roll < 85) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 3);
            end else if (stall_roll < 97) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(4, 15);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(30, 90);
            end
        end
    end

    function automatic tracker_req_t rect_req(input int lx, input int ty, input int rx,
                                              input int by);
        tracker_req_t r;
        r.kind   = dtst_pkg::REQ_MARK_RECT;
        r.lx     = lx[15:0];
        r.ty     = ty[15:0];
        r.rx     = rx[15:0];
        r.by     = by[15:0];
        r.tile   = 10'($urandom);
        r.sector = 10'($urandom);
        return r;
    endfunction

    function automatic tracker_req_t plain_req(input logic [2:0] kind, input int tile,
                                               input int sector);
        tracker_req_t r;
        r        = rect_req($urandom, $urandom, $urandom, $urandom);
        r.kind   = kind;
        r.tile   = tile[9:0];
        r.sector = sector[9:0];
        return r;
    endfunction

    // Mostly near the canvas, sometimes anywhere in range, sometimes a border value.
    function automatic logic signed [15:0] pick_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 16'($urandom_range(0, CANVAS_W + 40) - 20);
        if (roll < 85) return 16'($urandom);
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'(CANVAS_W - 1);
            default: return 16'(CANVAS_W);
        endcase
    endfunction

    function automatic tracker_req_t pick_req();
        tracker_req_t r;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)      r.kind = dtst_pkg::REQ_MARK_RECT;
        else if (roll < 39) r.kind = dtst_pkg::REQ_MARK_ALL;
        else if (roll < 54) r.kind = dtst_pkg::REQ_CAPTURE;
        else if (roll < 69) r.kind = dtst_pkg::REQ_ACK;
        else if (roll < 93) r.kind = dtst_pkg::REQ_QUERY;
        else if (roll < 96) r.kind = dtst_pkg::REQ_CLEAR;
        else                r.kind = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
        r.lx = pick_coord();
        r.ty = pick_coord();
        // Most rectangles are small and well ordered; the rest are arbitrary.
        r.rx = ($urandom_range(0, 99) < 70) ? 16'(r.lx + $urandom_range(0, 60)) : pick_coord();
        r.by = ($urandom_range(0, 99) < 70) ? 16'(r.ty + $urandom_range(0, 60)) : pick_coord();
        r.tile   = ($urandom_range(0, 99) < 80) ? 10'($urandom_range(0, TILE_COUNT - 1))
                                                : 10'($urandom);
        r.sector = ($urandom_range(0, 99) < 80) ? 10'($urandom_range(0, SECTOR_COUNT - 1))
                                                : 10'($urandom);
        return r;
    endfunction

    // Drives one request, holds it until the block takes it, then maybe idles.
    task automatic send_req(input tracker_req_t r);
        int roll;
        int gap;
        i_in_valid      <= 1'b1;
        i_req_type      <= r.kind;
        i_left_x        <= r.lx;
        i_top_y         <= r.ty;
        i_right_x       <= r.rx;
        i_bottom_y      <= r.by;
        i_tile_number   <= r.tile;
        i_sector_number <= r.sector;
        do @(posedge i_clk); while (o_in_stall);
        roll = $urandom_range(0, 99);
        if (calm_items > 0) begin
            calm_items--;
            gap = 0;
        end else if (roll < 55) gap = 0;
        else if (roll < 85)     gap = $urandom_range(1, 3);
        else if (roll < 97)     gap = $urandom_range(4, 20);
        else                    gap = $urandom_range(40, 90);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_req(plain_req(dtst_pkg::REQ_QUERY, 0, 0));
        send_req(rect_req(-32768, -32768, 32767, 32767));
        send_req(plain_req(dtst_pkg::REQ_QUERY, TILE_COUNT - 1, SECTOR_COUNT - 1));
        send_req(plain_req(dtst_pkg::REQ_CAPTURE, 0, 0));
        // Tile and sector numbers beyond the stores read as clear.
        send_req(plain_req(dtst_pkg::REQ_QUERY, 1023, 1023));
        send_req(plain_req(dtst_pkg::REQ_ACK, 0, SECTOR_COUNT - 1));
        send_req(plain_req(dtst_pkg::REQ_ACK, 0, 1023));
        send_req(plain_req(dtst_pkg::REQ_ACK, 0, SECTOR_COUNT));
        send_req(plain_req(dtst_pkg::REQ_QUERY, 0, SECTOR_COUNT - 1));
        // Rectangles wholly off each side of the canvas are dropped.
        send_req(rect_req(-100, 10, -1, 20));
        send_req(rect_req(10, -100, 20, -1));
        send_req(rect_req(CANVAS_W, 10, CANVAS_W + 50, 20));
        send_req(rect_req(10, CANVAS_W, 20, 32767));
        // Partly off the canvas, then inverted, then a single corner pixel.
        send_req(rect_req(-5, -5, 20, 3));
        send_req(rect_req(100, 10, 50, 40));
        send_req(rect_req(CANVAS_W - 1, CANVAS_W - 1, CANVAS_W - 1, CANVAS_W - 1));
        send_req(plain_req(dtst_pkg::REQ_QUERY, TILE_COUNT - 1, 0));
        send_req(plain_req(dtst_pkg::REQ_CAPTURE, 0, 0));
        send_req(plain_req(dtst_pkg::REQ_MARK_ALL, 0, 0));
        send_req(plain_req(REQ_SPARE_6, 1, 1));
        send_req(plain_req(REQ_SPARE_7, 2, 2));
        send_req(plain_req(dtst_pkg::REQ_CAPTURE, 0, 0));
        send_req(plain_req(dtst_pkg::REQ_CLEAR, 0, 0));
        send_req(plain_req(dtst_pkg::REQ_QUERY, 17, 4));
        send_req(rect_req(0, 0, 0, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == DRAIN_ITEM) drain_results();
            if (n % 200 == 100) calm_items = 40;
            send_req(pick_req());
        end

        drain_results();
        repeat (SECTOR_COUNT + 8) @(posedge i_clk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
